@@ design/brt_pkg.sv @@
// shared constants, types and helpers of the bidirectional relation table
package brt_pkg;

  // index width is fixed by the item fields
  localparam int IDX_W = 6;
  localparam int SPAN  = 1 << IDX_W;

  // populated range of rows and columns
  localparam int ROWS = 64;
  localparam int COLS = 64;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [SPAN-1:0]  word_t;

  localparam idx_t IDX_MAX = idx_t'(SPAN - 1);

  // command codes of an input item
  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_DROP = 2'd1,
    KIND_ROWQ = 2'd2,
    KIND_COLQ = 2'd3
  } kind_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_ROW_LOAD,
    ST_SCAN_ROW,
    ST_SCAN_COL,
    ST_FLUSH
  } state_t;

  // scan events from the sequencer to the result stage
  typedef struct packed {
    logic clear;
    logic hit;
    idx_t idx;
    logic flush;
  } scan_t;

  function automatic logic row_ok(input idx_t r);
    return 32'(r) < ROWS;
  endfunction

  function automatic logic col_ok(input idx_t c);
    return 32'(c) < COLS;
  endfunction

endpackage

@@ design/brt_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
module brt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/brt_emit.sv @@
// result stage: holds one found member back so the final one carries last
module brt_emit
  import brt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  scan_t scan,
  output logic  out_valid,
  output idx_t  out_member_index,
  output logic  out_none_found,
  output logic  out_last
);

  logic pend_vld_r, pend_vld_nxt;
  idx_t pend_idx_r, pend_idx_nxt;
  logic ov_r, ov_nxt;
  idx_t idx_r, idx_nxt;
  logic none_r, none_nxt;
  logic last_r, last_nxt;

  // pending member and output register update
  always_comb begin
    pend_vld_nxt = pend_vld_r;
    pend_idx_nxt = pend_idx_r;
    ov_nxt       = 1'b0;
    idx_nxt      = pend_idx_r;
    none_nxt     = 1'b0;
    last_nxt     = 1'b0;
    if (scan.clear) begin
      pend_vld_nxt = 1'b0;
    end else if (scan.hit) begin
      // a new member releases the previous one, not last
      ov_nxt       = pend_vld_r;
      pend_vld_nxt = 1'b1;
      pend_idx_nxt = scan.idx;
    end else if (scan.flush) begin
      // end of run: pending member or the empty-set item
      ov_nxt       = 1'b1;
      last_nxt     = 1'b1;
      none_nxt     = !pend_vld_r;
      idx_nxt      = pend_vld_r ? pend_idx_r : '0;
      pend_vld_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      ov_r       <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    idx_r      <= idx_nxt;
    none_r     <= none_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid        = ov_r;
  assign out_member_index = idx_r;
  assign out_none_found   = none_r;
  assign out_last         = last_r;

  // empty-set item is always final with a zero index
  a_none_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_none_found |-> out_last && (out_member_index == '0))
    else $error("none_found item without last or with nonzero index");

  // a member item while a member is pending is never final
  a_hit_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    scan.hit && !scan.clear && pend_vld_r |=> out_valid && !out_last)
    else $error("released member wrongly marked last");

endmodule

@@ design/bidirectional_relation_table_unit.sv @@
// top level of the bidirectional relation table: sequencer, row ram, result stage
//
// Keeps a 64 x 64 relation bit matrix in a single ram, one row per word, with
// a valid bit per row so that reset empties the table at once (no clearing
// pass). An item is taken when start is high and busy is low. Add and drop
// read the row and write it back: busy during the write-back, no result. A
// row query reads the row once and then checks one column per cycle; a
// column query reads one row per cycle through the ram read port and checks
// the selected bit. Either emits the members in ascending order at one per
// cycle at most, the final one marked last, or a single none_found item for
// an empty set. A row query is busy through the row load, column scan and
// flush, a column query through the row scan and flush, a query with an
// index out of range through the flush alone. Results appear on out_valid
// for one cycle each and must be taken then; the last result of a query
// comes out in the first cycle with busy low again.
module bidirectional_relation_table_unit
  import brt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_kind,
  input  idx_t       in_row_index,
  input  idx_t       in_col_index,
  output logic       out_valid,
  output idx_t       out_member_index,
  output logic       out_none_found,
  output logic       out_last
);

  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt;
  idx_t   row_r, row_nxt;
  idx_t   col_r, col_nxt;
  idx_t   cnt_r, cnt_nxt;
  word_t  word_r, word_nxt;
  word_t  row_vld_r, row_vld_nxt;

  logic   ram_we;
  logic   ram_re;
  idx_t   ram_raddr;
  word_t  ram_rdata;
  word_t  cur_word;
  word_t  bit_sel;
  word_t  upd_word;
  scan_t  scan;
  kind_t  in_kind_e;

  assign in_kind_e = kind_t'(in_kind);

  // row word as seen by the logic: unwritten rows read as empty
  assign cur_word = row_vld_r[row_r] ? ram_rdata : '0;
  assign bit_sel  = {{(SPAN-1){1'b0}}, 1'b1} << col_r;
  assign upd_word = (kind_r == KIND_ADD) ? (cur_word | bit_sel) : (cur_word & ~bit_sel);

  brt_ram #(
    .WIDTH (SPAN),
    .DEPTH (SPAN)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_r),
    .wdata (upd_word),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer next state and outputs
  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    cnt_nxt     = cnt_r;
    word_nxt    = word_r;
    row_vld_nxt = row_vld_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = in_row_index;
    scan        = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          kind_nxt = in_kind_e;
          row_nxt  = in_row_index;
          col_nxt  = in_col_index;
          case (in_kind_e)
            KIND_ADD, KIND_DROP: begin
              if (row_ok(in_row_index) && col_ok(in_col_index)) begin
                ram_re    = 1'b1;
                state_nxt = ST_UPD;
              end
            end
            KIND_ROWQ: begin
              scan.clear = 1'b1;
              if (row_ok(in_row_index)) begin
                ram_re    = 1'b1;
                state_nxt = ST_ROW_LOAD;
              end else begin
                state_nxt = ST_FLUSH;
              end
            end
            KIND_COLQ: begin
              scan.clear = 1'b1;
              if (col_ok(in_col_index)) begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                cnt_nxt   = '0;
                state_nxt = ST_SCAN_COL;
              end else begin
                state_nxt = ST_FLUSH;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_UPD: begin
        // write back the modified row
        ram_we              = 1'b1;
        row_vld_nxt[row_r]  = 1'b1;
        state_nxt           = ST_IDLE;
      end
      ST_ROW_LOAD: begin
        word_nxt  = cur_word;
        cnt_nxt   = '0;
        state_nxt = ST_SCAN_ROW;
      end
      ST_SCAN_ROW: begin
        // one column per cycle
        scan.hit = word_r[cnt_r] && col_ok(cnt_r);
        scan.idx = cnt_r;
        cnt_nxt  = idx_t'(cnt_r + 1'b1);
        if (cnt_r == IDX_MAX) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_SCAN_COL: begin
        // row cnt_r is on the read port; fetch the next row meanwhile
        scan.hit  = row_vld_r[cnt_r] && ram_rdata[col_r] && row_ok(cnt_r);
        scan.idx  = cnt_r;
        cnt_nxt   = idx_t'(cnt_r + 1'b1);
        ram_raddr = idx_t'(cnt_r + 1'b1);
        if (cnt_r == IDX_MAX) begin
          state_nxt = ST_FLUSH;
        end else begin
          ram_re = 1'b1;
        end
      end
      ST_FLUSH: begin
        scan.flush = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      row_vld_r <= '0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      row_vld_r <= row_vld_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // latched item fields and scanned row
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    word_r <= word_nxt;
  end

  assign busy = (state_r != ST_IDLE);

  brt_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .scan             (scan),
    .out_valid        (out_valid),
    .out_member_index (out_member_index),
    .out_none_found   (out_none_found),
    .out_last         (out_last)
  );

  // every query run ends with a final item right after the flush
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FLUSH |=> out_valid && out_last)
    else $error("query run ended without a final item");

  // items only come out of scanning or flushing
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_SCAN_ROW || $past(state_r) == ST_SCAN_COL ||
                   $past(state_r) == ST_FLUSH))
    else $error("item emitted outside a query run");

  // a write-back only ever follows an accepted add or drop
  a_upd_origin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |-> $past(state_r) == ST_IDLE && $past(start) &&
                          ($past(in_kind_e) == KIND_ADD || $past(in_kind_e) == KIND_DROP))
    else $error("write-back without an update item");

endmodule

@@ verif/tb_bidirectional_relation_table_unit.sv @@
// testbench of the bidirectional relation table: directed table, random items, scoreboard
`timescale 1ns / 1ps

module tb_bidirectional_relation_table_unit;
  import brt_pkg::*;

  localparam int DIR_N       = 25;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 80;

  // one result item of a query run
  typedef struct packed {
    idx_t member;
    logic none;
    logic last;
  } member_t;

  // one row of the directed table; typed rows carry their single result
  typedef struct packed {
    kind_t kind;
    idx_t  row;
    idx_t  col;
    logic  typed;
    idx_t  member;
    logic  none;
  } plan_row_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_kind;
  idx_t       in_row_index;
  idx_t       in_col_index;
  logic       out_valid;
  idx_t       out_member_index;
  logic       out_none_found;
  logic       out_last;

  // predictor copy of the relation matrix, bit c of word r is pair (r, c)
  logic [SPAN-1:0] relation [SPAN];
  member_t         pending_members [$];
  plan_row_t       plan [DIR_N];

  int  mismatches;
  int  cycles;
  int  items_sent;
  bit  idle_on;

  bidirectional_relation_table_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .out_valid        (out_valid),
    .out_member_index (out_member_index),
    .out_none_found   (out_none_found),
    .out_last         (out_last)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_members.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) begin
      $display("mismatch at cycle %0d: %s", cycles, msg);
    end
    mismatches++;
  endtask

  // update the matrix copy, or queue the members a query will emit
  function automatic void predict_item(input kind_t k, input idx_t r, input idx_t c);
    member_t run [$];
    member_t m;
    logic    hit;
    bit      r_ok;
    bit      c_ok;
    r_ok = int'(r) < ROWS;
    c_ok = int'(c) < COLS;
    case (k)
      KIND_ADD: begin
        if (r_ok && c_ok) relation[r][c] = 1'b1;
      end
      KIND_DROP: begin
        if (r_ok && c_ok) relation[r][c] = 1'b0;
      end
      default: begin
        for (int i = 0; i < SPAN; i++) begin
          if (k == KIND_ROWQ) begin
            hit = r_ok && (i < COLS) && relation[r][i];
          end else begin
            hit = c_ok && (i < ROWS) && relation[i][c];
          end
          if (hit) begin
            m.member = idx_t'(i);
            m.none   = 1'b0;
            m.last   = 1'b0;
            run.push_back(m);
          end
        end
        if (run.size() == 0) begin
          m.member = '0;
          m.none   = 1'b1;
          m.last   = 1'b1;
          run.push_back(m);
        end else begin
          run[run.size()-1].last = 1'b1;
        end
        foreach (run[j]) pending_members.push_back(run[j]);
      end
    endcase
  endfunction

  // present one item, wait for it to be taken, then record what it causes
  task automatic send_item(input kind_t k, input idx_t r, input idx_t c,
                           input bit typed, input member_t typed_res);
    int gap;
    if (idle_on && $urandom_range(99) < 37) begin
      start <= 1'b0;
      gap = ($urandom_range(9) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_kind      <= k;
    in_row_index <= r;
    in_col_index <= c;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (typed) begin
      pending_members.push_back(typed_res);
    end else begin
      predict_item(k, r, c);
    end
    items_sent++;
  endtask

  // index biased toward both ends of the range
  function automatic idx_t pick_index();
    if ($urandom_range(1) == 0) begin
      return idx_t'($urandom_range(63));
    end else if ($urandom_range(1) == 0) begin
      return idx_t'($urandom_range(3));
    end
    return idx_t'($urandom_range(60, 63));
  endfunction

  task automatic random_items(input int n);
    kind_t   k;
    int      roll;
    member_t unused;
    unused = '0;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < 45) k = KIND_ADD;
      else if (roll < 60) k = KIND_DROP;
      else if (roll < 80) k = KIND_ROWQ;
      else k = KIND_COLQ;
      send_item(k, pick_index(), pick_index(), 1'b0, unused);
    end
  endtask

  // fill a whole row or column, then list it for a full 64 member run
  task automatic sweep_line(input bit by_row);
    idx_t    line;
    member_t unused;
    unused = '0;
    line   = pick_index();
    for (int i = 0; i < SPAN; i++) begin
      if (by_row) send_item(KIND_ADD, line, idx_t'(i), 1'b0, unused);
      else send_item(KIND_ADD, idx_t'(i), line, 1'b0, unused);
    end
    if (by_row) send_item(KIND_ROWQ, line, pick_index(), 1'b0, unused);
    else send_item(KIND_COLQ, pick_index(), line, 1'b0, unused);
  endtask

  // result check against the oldest expectation
  always @(posedge clk) begin
    member_t exp_m;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (pending_members.size() == 0) begin
        report_mismatch($sformatf("unexpected result member %0d none %b last %b",
                                  out_member_index, out_none_found, out_last));
      end else begin
        exp_m = pending_members.pop_front();
        if (out_valid !== 1'b1) begin
          report_mismatch("out_valid unknown");
        end
        if (out_member_index !== exp_m.member) begin
          report_mismatch($sformatf("member_index %0d, expected %0d",
                                    out_member_index, exp_m.member));
        end
        if (out_none_found !== exp_m.none) begin
          report_mismatch($sformatf("none_found %b, expected %b",
                                    out_none_found, exp_m.none));
        end
        if (out_last !== exp_m.last) begin
          report_mismatch($sformatf("last %b, expected %b (member %0d)",
                                    out_last, exp_m.last, exp_m.member));
        end
      end
    end
  end

  // main sequence
  initial begin
    member_t tr;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_kind      = KIND_ADD;
    in_row_index = '0;
    in_col_index = '0;
    mismatches   = 0;
    cycles       = 0;
    items_sent   = 0;
    idle_on      = 1'b1;
    for (int r = 0; r < SPAN; r++) relation[r] = '0;

    // empty table, both corners, repeats, ignored fields
    plan = '{
      '{KIND_ROWQ, 6'd0,  6'd0,  1'b1, 6'd0,  1'b1},
      '{KIND_COLQ, 6'd63, 6'd63, 1'b1, 6'd0,  1'b1},
      '{KIND_ROWQ, 6'd63, 6'd0,  1'b1, 6'd0,  1'b1},
      '{KIND_ADD,  6'd0,  6'd0,  1'b0, 6'd0,  1'b0},
      '{KIND_ADD,  6'd0,  6'd63, 1'b0, 6'd0,  1'b0},
      '{KIND_ADD,  6'd63, 6'd63, 1'b0, 6'd0,  1'b0},
      '{KIND_ADD,  6'd63, 6'd0,  1'b0, 6'd0,  1'b0},
      '{KIND_ROWQ, 6'd0,  6'd5,  1'b0, 6'd0,  1'b0},
      '{KIND_COLQ, 6'd17, 6'd63, 1'b0, 6'd0,  1'b0},
      '{KIND_ROWQ, 6'd63, 6'd63, 1'b0, 6'd0,  1'b0},
      '{KIND_COLQ, 6'd0,  6'd0,  1'b0, 6'd0,  1'b0},
      '{KIND_ADD,  6'd0,  6'd0,  1'b0, 6'd0,  1'b0},
      '{KIND_DROP, 6'd0,  6'd63, 1'b0, 6'd0,  1'b0},
      '{KIND_DROP, 6'd0,  6'd63, 1'b0, 6'd0,  1'b0},
      '{KIND_ROWQ, 6'd0,  6'd42, 1'b1, 6'd0,  1'b0},
      '{KIND_COLQ, 6'd0,  6'd63, 1'b1, 6'd63, 1'b0},
      '{KIND_DROP, 6'd63, 6'd63, 1'b0, 6'd0,  1'b0},
      '{KIND_DROP, 6'd63, 6'd0,  1'b0, 6'd0,  1'b0},
      '{KIND_ROWQ, 6'd63, 6'd0,  1'b1, 6'd0,  1'b1},
      '{KIND_ADD,  6'd21, 6'd42, 1'b0, 6'd0,  1'b0},
      '{KIND_ADD,  6'd42, 6'd21, 1'b0, 6'd0,  1'b0},
      '{KIND_COLQ, 6'd63, 6'd42, 1'b1, 6'd21, 1'b0},
      '{KIND_ROWQ, 6'd42, 6'd0,  1'b1, 6'd21, 1'b0},
      '{KIND_DROP, 6'd0,  6'd0,  1'b0, 6'd0,  1'b0},
      '{KIND_COLQ, 6'd0,  6'd0,  1'b1, 6'd0,  1'b1}
    };

    // synchronous reset
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIR_N; i++) begin
      tr.member = plan[i].member;
      tr.none   = plan[i].none;
      tr.last   = 1'b1;
      send_item(plan[i].kind, plan[i].row, plan[i].col, plan[i].typed, tr);
    end

    // random items around a full-row sweep; middle stretch never idles
    random_items(25);
    sweep_line(1'b1);
    idle_on = 1'b0;
    random_items(30);
    idle_on = 1'b1;
    random_items(25);

    // drain
    start <= 1'b0;
    while (pending_members.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
